@@ rtl/dcm_pkg.sv @@
// shared types, reset values and saturation helpers for the motor plant step
package dcm_pkg;

   // register reset values, unsigned Q16.16
   localparam logic [31:0] INV_MASS_RESET     = 32'd655360;
   localparam logic [31:0] FRICTION_RESET     = 32'd65536;
   localparam logic [31:0] MOTOR_GAIN_RESET   = 32'd65536;
   localparam logic [31:0] BACKEMF_GAIN_RESET = 32'd0;

   // shift-add steps for one product, one multiplier bit per cycle
   localparam int unsigned MUL_STEPS = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIN,
      ST_COMB,
      ST_OUT
   } state_type;

   // products in the order one tick needs them
   typedef enum logic [2:0] {
      OP_BEMF,
      OP_DRIVE,
      OP_DRAG,
      OP_ACCEL,
      OP_SPEED,
      OP_POS
   } op_type;

   typedef enum logic [1:0] {
      REG_INV_MASS,
      REG_FRICTION,
      REG_MOTOR_GAIN,
      REG_BACKEMF_GAIN
   } csr_idx_type;

   // floor of a 64-bit product over 2^16, clamped to signed 32 bits
   function automatic logic [31:0] sat_prod16(input logic [63:0] p);
      logic [31:0] r;
      if (p[63:47] == {17{p[47]}}) begin
         r = p[47:16];
      end else if (p[63]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   // 33-bit signed sum clamped to signed 32 bits
   function automatic logic [31:0] sat_sum33(input logic [32:0] s);
      logic [31:0] r;
      if (s[32] == s[31]) begin
         r = s[31:0];
      end else if (s[32]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   // 49-bit signed sum clamped to signed 48 bits
   function automatic logic [47:0] sat_sum49(input logic [48:0] s);
      logic [47:0] r;
      if (s[48] == s[47]) begin
         r = s[47:0];
      end else if (s[48]) begin
         r = 48'h8000_0000_0000;
      end else begin
         r = 48'h7FFF_FFFF_FFFF;
      end
      return r;
   endfunction

endpackage

@@ rtl/dc_motor_plant_euler_step.sv @@
// dc motor plant: one semi-implicit euler step per word, bit-serial multiplier
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | drive_effort (s32), time_step (u24)
//   rsp     | out       | rsp_valid/rsp_stall  | position_out (s48), speed_out (s32)
//   csr     | in/out    | psel/penable/pready  | paddr[3:0], pwdata/prdata 32 bits
//
// Six products go through one shift-add multiplier at one multiplier bit per
// cycle, each followed by a scale-and-clamp step (ST_FIN) and an add-and-clamp
// step (ST_COMB); the result is then loaded in ST_OUT, and the next word is
// taken only once the block is back in ST_IDLE.
// Reset (synchronous) loads the register defaults and zeroes speed and position.
// req_stall is high while a word is in work; a finished word waits in the
// output register under rsp_stall, and the next word may be taken meanwhile.
module dc_motor_plant_euler_step
   import dcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_drive_effort,
   input  logic [23:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_position_out,
   output logic signed [31:0] rsp_speed_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int unsigned CNT_W = $clog2(MUL_STEPS);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [32:0]        hi_ff, hi_in;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        g_ff, g_in;
   logic [31:0]        x_ff, x_in;
   logic [31:0]        drive_ff, drive_in;
   logic [31:0]        effort_ff, effort_in;
   logic [23:0]        dt_ff, dt_in;
   logic [31:0]        speed_ff, speed_in;
   logic [47:0]        position_ff, position_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_position_ff, rsp_position_in;
   logic [31:0]        rsp_speed_ff, rsp_speed_in;
   logic [31:0]        inv_mass_ff, inv_mass_in;
   logic [31:0]        friction_ff, friction_in;
   logic [31:0]        motor_gain_ff, motor_gain_in;
   logic [31:0]        backemf_gain_ff, backemf_gain_in;

   logic               csr_write;
   csr_idx_type        csr_idx;
   op_type             op_succ;
   op_type             load_op;
   logic [31:0]        mcand;
   logic [31:0]        load_mplier;
   logic [32:0]        mul_sum;
   logic [63:0]        prod;

   // register file access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = csr_idx_type'(paddr[3:2]);

   always_comb begin
      inv_mass_in     = inv_mass_ff;
      friction_in     = friction_ff;
      motor_gain_in   = motor_gain_ff;
      backemf_gain_in = backemf_gain_ff;
      case (csr_idx)
         REG_INV_MASS: begin
            prdata = inv_mass_ff;
            if (csr_write) inv_mass_in = pwdata;
         end
         REG_FRICTION: begin
            prdata = friction_ff;
            if (csr_write) friction_in = pwdata;
         end
         REG_MOTOR_GAIN: begin
            prdata = motor_gain_ff;
            if (csr_write) motor_gain_in = pwdata;
         end
         REG_BACKEMF_GAIN: begin
            prdata = backemf_gain_ff;
            if (csr_write) backemf_gain_in = pwdata;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // operand selection for the shared multiplier
   assign op_succ = op_type'(op_ff + 3'd1);
   assign load_op = (state_ff == ST_IDLE) ? OP_BEMF : op_succ;

   always_comb begin
      case (op_ff)
         OP_BEMF, OP_DRAG, OP_POS: mcand = speed_ff;
         default:                  mcand = x_ff;
      endcase
   end

   always_comb begin
      case (load_op)
         OP_BEMF:          load_mplier = backemf_gain_ff;
         OP_DRIVE:         load_mplier = motor_gain_ff;
         OP_DRAG:          load_mplier = friction_ff;
         OP_ACCEL:         load_mplier = inv_mass_ff;
         OP_SPEED, OP_POS: load_mplier = {8'd0, dt_ff};
         default:          load_mplier = '0;
      endcase
   end

   // one shift-add step: add multiplicand on the low multiplier bit, then shift
   assign mul_sum = hi_ff + (lo_ff[0] ? {mcand[31], mcand} : 33'd0);
   assign prod    = {hi_ff[31:0], lo_ff};

   // sequencer and datapath next values
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      cnt_in          = cnt_ff;
      hi_in           = hi_ff;
      lo_in           = lo_ff;
      g_in            = g_ff;
      x_in            = x_ff;
      drive_in        = drive_ff;
      effort_in       = effort_ff;
      dt_in           = dt_ff;
      speed_in        = speed_ff;
      position_in     = position_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_position_in = rsp_position_ff;
      rsp_speed_in    = rsp_speed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               effort_in = req_drive_effort;
               dt_in     = req_time_step;
               op_in     = OP_BEMF;
               hi_in     = '0;
               lo_in     = load_mplier;
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            hi_in  = {mul_sum[32], mul_sum[32:1]};
            lo_in  = {mul_sum[0], lo_ff[31:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // time-step products scale by 2^-24 and always fit 32 bits
            if (op_ff == OP_SPEED || op_ff == OP_POS) begin
               g_in = prod[55:24];
            end else begin
               g_in = sat_prod16(prod);
            end
            state_in = ST_COMB;
         end
         ST_COMB: begin
            case (op_ff)
               OP_BEMF:  x_in = sat_sum33({effort_ff[31], effort_ff} - {g_ff[31], g_ff});
               OP_DRIVE: drive_in = g_ff;
               OP_DRAG:  x_in = sat_sum33({drive_ff[31], drive_ff} - {g_ff[31], g_ff});
               OP_ACCEL: x_in = g_ff;
               OP_SPEED: speed_in = sat_sum33({speed_ff[31], speed_ff} + {g_ff[31], g_ff});
               OP_POS: begin
                  position_in = sat_sum49({position_ff[47], position_ff}
                                          + {{17{g_ff[31]}}, g_ff});
               end
               default: begin
               end
            endcase
            if (op_ff == OP_POS) begin
               state_in = ST_OUT;
            end else begin
               op_in    = op_succ;
               hi_in    = '0;
               lo_in    = load_mplier;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = position_ff;
               rsp_speed_in    = speed_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         speed_ff        <= '0;
         position_ff     <= '0;
         inv_mass_ff     <= INV_MASS_RESET;
         friction_ff     <= FRICTION_RESET;
         motor_gain_ff   <= MOTOR_GAIN_RESET;
         backemf_gain_ff <= BACKEMF_GAIN_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         speed_ff        <= speed_in;
         position_ff     <= position_in;
         inv_mass_ff     <= inv_mass_in;
         friction_ff     <= friction_in;
         motor_gain_ff   <= motor_gain_in;
         backemf_gain_ff <= backemf_gain_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      cnt_ff          <= cnt_in;
      hi_ff           <= hi_in;
      lo_ff           <= lo_in;
      g_ff            <= g_in;
      x_ff            <= x_in;
      drive_ff        <= drive_in;
      effort_ff       <= effort_in;
      dt_ff           <= dt_in;
      rsp_position_ff <= rsp_position_in;
      rsp_speed_ff    <= rsp_speed_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position_out = rsp_position_ff;
   assign rsp_speed_out    = rsp_speed_ff;

endmodule

@@ test/plant_checker.sv @@
// checker for the motor plant step: tracks register writes, predicts each tick, compares results
module plant_checker
   import dcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_drive_effort,
   input  logic [23:0]        req_time_step,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [47:0] rsp_position_out,
   input  logic signed [31:0] rsp_speed_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 mismatch_count,
   output int                 words_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint S32_HI = 64'sh7FFF_FFFF;
   localparam longint S32_LO = -S32_HI - 1;
   localparam longint S48_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint S48_LO = -S48_HI - 1;

   typedef struct {
      logic signed [47:0] position;
      logic signed [31:0] speed;
   } plant_state_type;

   // predicted registers and plant state
   logic [31:0]     inv_mass     = INV_MASS_RESET;
   logic [31:0]     friction     = FRICTION_RESET;
   logic [31:0]     motor_gain   = MOTOR_GAIN_RESET;
   logic [31:0]     backemf_gain = BACKEMF_GAIN_RESET;
   longint          plant_speed    = 0;
   longint          plant_position = 0;
   plant_state_type expected_states[$];

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // unsigned q16.16 gain times signed q16.16 value, floored back to q16.16 and clamped
   function automatic longint gain_product(input logic [31:0] g, input longint v);
      longint wide;
      wide = longint'({32'd0, g}) * v;
      return clamp(wide >>> 16, S32_LO, S32_HI);
   endfunction

   // one semi-implicit euler tick: speed first, then position from the new speed
   function automatic void advance_plant(input logic signed [31:0] effort,
                                         input logic [23:0] dt);
      longint step_dt, bemf, volts, drive, drag, net_force, accel;
      step_dt   = longint'({40'd0, dt});
      bemf      = gain_product(backemf_gain, plant_speed);
      volts     = clamp(longint'(effort) - bemf, S32_LO, S32_HI);
      drive     = gain_product(motor_gain, volts);
      drag      = gain_product(friction, plant_speed);
      net_force = clamp(drive - drag, S32_LO, S32_HI);
      accel     = gain_product(inv_mass, net_force);
      plant_speed    = clamp(plant_speed + ((accel * step_dt) >>> 24), S32_LO, S32_HI);
      plant_position = clamp(plant_position + ((plant_speed * step_dt) >>> 24),
                             S48_LO, S48_HI);
   endfunction

   always @(posedge clock) begin
      plant_state_type want;
      plant_state_type next_state;
      if (reset) begin
         inv_mass       = INV_MASS_RESET;
         friction       = FRICTION_RESET;
         motor_gain     = MOTOR_GAIN_RESET;
         backemf_gain   = BACKEMF_GAIN_RESET;
         plant_speed    = 0;
         plant_position = 0;
         mismatch_count = 0;
         expected_states.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (csr_idx_type'(paddr[3:2]))
               REG_INV_MASS:     inv_mass     = pwdata;
               REG_FRICTION:     friction     = pwdata;
               REG_MOTOR_GAIN:   motor_gain   = pwdata;
               REG_BACKEMF_GAIN: backemf_gain = pwdata;
               default: ;
            endcase
         end
         // result words against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected result word, position %h speed %h",
                        $time, rsp_position_out, rsp_speed_out);
               mismatch_count++;
            end else begin
               want = expected_states.pop_front();
               if (rsp_position_out !== want.position) begin
                  $display("%0t: position expected %h actual %h",
                           $time, want.position, rsp_position_out);
                  mismatch_count++;
               end
               if (rsp_speed_out !== want.speed) begin
                  $display("%0t: speed expected %h actual %h",
                           $time, want.speed, rsp_speed_out);
                  mismatch_count++;
               end
            end
         end
         // accepted tick words
         if (req_valid && !req_stall) begin
            advance_plant(req_drive_effort, req_time_step);
            next_state.position = plant_position[47:0];
            next_state.speed    = plant_speed[31:0];
            expected_states.push_back(next_state);
         end
      end
      words_in_flight = expected_states.size();
   end

endmodule

@@ test/testbench.sv @@
// top of the motor plant step bench: clock, reset, tick and register stimulus, verdict
module testbench
   import dcm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_drive_effort = '0;
   logic [23:0]        req_time_step = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [47:0] rsp_position_out;
   logic signed [31:0] rsp_speed_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;
   int                 mismatch_count;
   int                 words_in_flight;
   logic               any_handshake;

   bit words_gappy = 1'b1;
   bit results_gappy = 1'b1;
   bit hold_off_pending = 1'b0;
   bit hold_off_done = 1'b0;
   int hold_left = 0;
   int idle_cycles = 0;

   dc_motor_plant_euler_step dut (.*);

   plant_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, plus one long counted hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_pending && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= results_gappy && ($urandom_range(99) < 20);
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   assign any_handshake = (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                          || (psel && penable && pready);

   always @(posedge clock) begin
      if (any_handshake) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // offer one tick word, with random gaps ahead of it
   task automatic push_word(input logic [31:0] effort, input logic [23:0] dt);
      @(negedge clock);
      while (words_gappy && ($urandom_range(99) < 20)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_drive_effort <= effort;
      req_time_step    <= dt;
      do @(posedge clock); while (req_stall);
   endtask

   // setup and access cycles of one register write
   task automatic csr_write(input csr_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_gains(input logic [31:0] mass_inv, input logic [31:0] fric,
                            input logic [31:0] mgain, input logic [31:0] bemf);
      csr_write(REG_INV_MASS, mass_inv);
      csr_write(REG_FRICTION, fric);
      csr_write(REG_MOTOR_GAIN, mgain);
      csr_write(REG_BACKEMF_GAIN, bemf);
   endtask

   // stop offering, wait for every predicted word, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (words_in_flight != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_effort();
      int s;
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3, 4, 5: begin
            s = int'($urandom_range(2097152)) - 1048576;
            return s;
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [23:0] pick_step();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(9))
         0: return 24'd0;
         1: return 24'hFF_FFFF;
         2, 3, 4: return 24'($urandom_range(4096));
         default: return r[23:0];
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         default: return $urandom_range(262144);
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset gains: zero step, extreme efforts and steps
      push_word(32'h7FFF_FFFF, 24'd0);
      push_word(32'h7FFF_FFFF, 24'hFF_FFFF);
      push_word(32'h8000_0000, 24'hFF_FFFF);
      push_word(32'h0000_0000, 24'd1);
      push_word(32'hFFFF_FFFF, 24'hFF_FFFF);
      push_word(32'h0000_0001, 24'd0);
      settle();

      // zero inverse mass: speed holds, position keeps moving
      set_gains(32'd0, FRICTION_RESET, MOTOR_GAIN_RESET, BACKEMF_GAIN_RESET);
      push_word(32'h7FFF_FFFF, 24'hFF_FFFF);
      push_word(32'h8000_0000, 24'hFF_FFFF);
      push_word(32'h0001_2345, 24'h80_0000);
      settle();

      // maximum gains, no damping: speed runs into both limits
      set_gains(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
      repeat (3) push_word(32'h7FFF_FFFF, 24'hFF_FFFF);
      repeat (3) push_word(32'h8000_0000, 24'hFF_FFFF);
      settle();

      // heavy damping and back-emf against a saturated speed
      set_gains(32'h0000_4000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_word(32'h7FFF_FFFF, 24'hFF_FFFF);
      push_word(32'h8000_0000, 24'h40_0000);
      push_word(32'h0000_0000, 24'hFF_FFFF);
      push_word(32'h0000_0001, 24'd1);
      settle();

      // random phases, one with no idling and one with a long result hold-off
      for (int phase = 0; phase < 8; phase++) begin
         set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
         words_gappy   = (phase != 4);
         results_gappy = (phase != 4);
         if (phase == 1) begin
            hold_off_pending = 1'b1;
         end
         repeat (105) push_word(pick_effort(), pick_step());
         settle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
